>>> rtl/core/lte_pkg.sv
`default_nettype none

package lte_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam int KIND_W     = 2;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int SPAN_W     = 32;
   localparam int EXP_W      = 33;
   localparam int DEFSPAN_W  = 17;
   localparam int MAXSPAN_W  = 20;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [DEFSPAN_W-1:0] DEF_SPAN_RST = 17'd3600;
   localparam logic [MAXSPAN_W-1:0] MAX_SPAN_RST = 20'd86400;

   typedef enum logic [KIND_W-1:0] {
      KIND_REG  = 2'd0,
      KIND_TICK = 2'd1,
      KIND_LIST = 2'd2
   } lte_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_REFRESHED = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_LISTED    = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_TICK      = 3'd5
   } lte_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_SPAN = 1'b0,
      CSR_MAX_SPAN     = 1'b1
   } lte_csr_type;

   typedef enum logic [1:0] {
      RSEL_ZERO = 2'd0,
      RSEL_IDX  = 2'd1,
      RSEL_NEXT = 2'd2,
      RSEL_TAIL = 2'd3
   } lte_rsel_type;

   typedef enum logic [1:0] {
      WSEL_REFRESH = 2'd0,
      WSEL_APPEND  = 2'd1,
      WSEL_MOVE    = 2'd2
   } lte_wsel_type;

   typedef enum logic {
      RLD_PEND  = 1'b0,
      RLD_ENTRY = 1'b1
   } lte_rld_type;

   typedef enum logic [3:0] {
      S_IDLE     = 4'd0,
      S_RG_FIRST = 4'd1,
      S_RG_CHK   = 4'd2,
      S_RG_END   = 4'd3,
      S_TICK     = 4'd4,
      S_SW_FIRST = 4'd5,
      S_SW_CHK   = 4'd6,
      S_SW_MOVE  = 4'd7,
      S_LS_FIRST = 4'd8,
      S_LS_OUT   = 4'd9,
      S_RESP     = 4'd10
   } lte_state_type;

   typedef struct packed {
      logic           latch;
      logic           idx_clr;
      logic           idx_inc;
      logic           rd_en;
      lte_rsel_type   rsel;
      logic           wr_en;
      lte_wsel_type   wsel;
      logic           cnt_inc;
      logic           cnt_dec;
      logic           now_inc;
      logic           set_status;
      lte_status_type status;
      logic           rsp_load;
      lte_rld_type    rld;
   } lte_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic full;
      logic hit;
      logic expired;
      logic slot_free;
   } lte_sts_type;

endpackage

`default_nettype wire

>>> rtl/core/lte_req_if.sv
`default_nettype none

interface lte_req_if;
   import lte_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [IP_W-1:0]     addr_ip;
   logic [PORT_W-1:0]   addr_port;
   logic [SPAN_W-1:0]   requested_lifespan;

   modport source (output valid, kind, addr_ip, addr_port, requested_lifespan, input ready);
   modport sink (input valid, kind, addr_ip, addr_port, requested_lifespan, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lte_rsp_if.sv
`default_nettype none

interface lte_rsp_if;
   import lte_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IP_W-1:0]     entry_ip;
   logic [PORT_W-1:0]   entry_port;
   logic [COUNT_W-1:0]  entry_count;
   logic                last;

   modport source (output valid, status, entry_ip, entry_port, entry_count, last, input ready);
   modport sink (input valid, status, entry_ip, entry_port, entry_count, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lte_csr_if.sv
`default_nettype none

interface lte_csr_if;
   import lte_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lease_table_with_expiry_core.sv
// Channel   Direction  Signals                                         Accepted when
// req_bus   in         kind, addr_ip, addr_port, requested_lifespan    valid && ready
// rsp_bus   out        status, entry_ip, entry_port, entry_count, last valid && ready
// csr_bus   in         index, data (0 default_lifespan, 1 max_lifespan) valid && ready
//
// A tick passes through the tick and result states. A register scans the live entries
// for a match, reading one table word per cycle from a single-port-read RAM. A list
// moves the tail into each expired slot, then lists the rest or reports the table empty.
// Reset is synchronous; the table needs no clearing pass and the block is ready at once.
// A stalled result waits in the output register while the next item is accepted.
`default_nettype none

module lease_table_with_expiry_core #(
   parameter int TABLE_ENTRIES = lte_pkg::TABLE_ENTRIES_DEF
) (
   input logic        clock,
   input logic        reset,
   lte_req_if.sink    req_bus,
   lte_rsp_if.source  rsp_bus,
   lte_csr_if.sink    csr_bus
);
   import lte_pkg::*;

   lte_cmd_type cmd;
   lte_sts_type sts;
   logic        req_ready;

   assign req_bus.ready = req_ready;

   lte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lte_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_addr_ip     (req_bus.addr_ip),
      .req_addr_port   (req_bus.addr_port),
      .req_span        (req_bus.requested_lifespan),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_entry_ip    (rsp_bus.entry_ip),
      .rsp_entry_port  (rsp_bus.entry_port),
      .rsp_entry_count (rsp_bus.entry_count),
      .rsp_last        (rsp_bus.last)
   );

endmodule

`default_nettype wire

>>> rtl/core/lte_ram.sv
`default_nettype none

module lte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lte_ctrl.sv
`default_nettype none

module lte_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [lte_pkg::KIND_W-1:0] req_kind,
   output logic                      req_ready,
   input  lte_pkg::lte_sts_type      sts,
   output lte_pkg::lte_cmd_type      cmd
);
   import lte_pkg::*;

   lte_state_type state_ff;
   lte_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (lte_kind_type'(req_kind))
                  KIND_REG:  state_in = S_RG_FIRST;
                  KIND_TICK: state_in = S_TICK;
                  KIND_LIST: state_in = S_SW_FIRST;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_RG_FIRST: state_in = sts.count_zero ? S_RG_END : S_RG_CHK;
         S_RG_CHK: begin
            if (sts.hit) begin
               state_in = S_RESP;
            end else if (sts.idx_last) begin
               state_in = S_RG_END;
            end
         end
         S_RG_END:   state_in = S_RESP;
         S_TICK:     state_in = S_RESP;
         S_SW_FIRST: state_in = sts.count_zero ? S_LS_FIRST : S_SW_CHK;
         S_SW_CHK: begin
            if (sts.expired) begin
               state_in = S_SW_MOVE;
            end else if (sts.idx_last) begin
               state_in = S_LS_FIRST;
            end
         end
         S_SW_MOVE:  state_in = sts.idx_last ? S_LS_FIRST : S_SW_CHK;
         S_LS_FIRST: state_in = sts.count_zero ? S_RESP : S_LS_OUT;
         S_LS_OUT: begin
            if (sts.slot_free && sts.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (sts.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch   = 1'b1;
               cmd.idx_clr = 1'b1;
            end
         end
         S_RG_FIRST: begin
            if (!sts.count_zero) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = RSEL_ZERO;
            end
         end
         S_RG_CHK: begin
            if (sts.hit) begin
               cmd.wr_en      = 1'b1;
               cmd.wsel       = WSEL_REFRESH;
               cmd.set_status = 1'b1;
               cmd.status     = ST_REFRESHED;
            end else if (!sts.idx_last) begin
               cmd.rd_en   = 1'b1;
               cmd.rsel    = RSEL_NEXT;
               cmd.idx_inc = 1'b1;
            end
         end
         S_RG_END: begin
            cmd.set_status = 1'b1;
            if (sts.full) begin
               cmd.status = ST_DROPPED;
            end else begin
               cmd.status  = ST_ADDED;
               cmd.wr_en   = 1'b1;
               cmd.wsel    = WSEL_APPEND;
               cmd.cnt_inc = 1'b1;
            end
         end
         S_TICK: begin
            cmd.now_inc    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_TICK;
         end
         S_SW_FIRST: begin
            if (!sts.count_zero) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = RSEL_ZERO;
            end
         end
         S_SW_CHK: begin
            if (sts.expired) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = RSEL_TAIL;
            end else if (!sts.idx_last) begin
               cmd.rd_en   = 1'b1;
               cmd.rsel    = RSEL_NEXT;
               cmd.idx_inc = 1'b1;
            end
         end
         S_SW_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wsel    = WSEL_MOVE;
            cmd.cnt_dec = 1'b1;
            if (!sts.idx_last) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = RSEL_IDX;
            end
         end
         S_LS_FIRST: begin
            if (sts.count_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_EMPTY;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rsel    = RSEL_ZERO;
               cmd.idx_clr = 1'b1;
            end
         end
         S_LS_OUT: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rld      = RLD_ENTRY;
               if (!sts.idx_last) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rsel    = RSEL_NEXT;
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rld      = RLD_PEND;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/lte_dpath.sv
`default_nettype none

module lte_dpath #(
   parameter int TABLE_ENTRIES = lte_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lte_pkg::lte_cmd_type          cmd,
   output lte_pkg::lte_sts_type          sts,
   input  logic [lte_pkg::IP_W-1:0]      req_addr_ip,
   input  logic [lte_pkg::PORT_W-1:0]    req_addr_port,
   input  logic [lte_pkg::SPAN_W-1:0]    req_span,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lte_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lte_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lte_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lte_pkg::IP_W-1:0]      rsp_entry_ip,
   output logic [lte_pkg::PORT_W-1:0]    rsp_entry_port,
   output logic [lte_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                          rsp_last
);
   import lte_pkg::*;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int CNT1_W = CNT_W + 1;
   localparam int WORD_W = IP_W + PORT_W + EXP_W;

   logic [DEFSPAN_W-1:0] def_span_ff, def_span_in;
   logic [MAXSPAN_W-1:0] max_span_ff, max_span_in;
   logic [IP_W-1:0]      now_ff, now_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IP_W-1:0]      lat_ip_ff;
   logic [PORT_W-1:0]    lat_port_ff;
   logic [EXP_W-1:0]     lat_exp_ff;
   lte_status_type       pend_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lte_status_type       rsp_status_ff;
   logic [IP_W-1:0]      rsp_ip_ff;
   logic [PORT_W-1:0]    rsp_port_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_last_ff;

   logic [SPAN_W-1:0]    span_sel;
   logic [EXP_W-1:0]     new_exp;
   logic [IDX_W-1:0]     idx_next;
   logic [IDX_W-1:0]     tail_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_word;
   logic [WORD_W-1:0]    rd_word;
   logic [IP_W-1:0]      rd_ip;
   logic [PORT_W-1:0]    rd_port;
   logic [EXP_W-1:0]     rd_exp;
   logic                 slot_free;

   lte_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_ip   = rd_word[WORD_W-1 -: IP_W];
   assign rd_port = rd_word[EXP_W +: PORT_W];
   assign rd_exp  = rd_word[EXP_W-1:0];

   // A lifespan of zero or above the limit falls back to the default.
   assign span_sel = ((req_span == '0) || (req_span > SPAN_W'(max_span_ff)))
                     ? SPAN_W'(def_span_ff) : req_span;
   assign new_exp  = EXP_W'(now_ff) + EXP_W'(span_sel);

   assign idx_next  = idx_ff + IDX_W'(1);
   assign tail_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.rsel)
         RSEL_ZERO: rd_addr = '0;
         RSEL_IDX:  rd_addr = idx_ff;
         RSEL_NEXT: rd_addr = idx_next;
         RSEL_TAIL: rd_addr = tail_idx;
      endcase
   end

   always_comb begin
      unique case (cmd.wsel)
         WSEL_REFRESH: begin
            wr_addr = idx_ff;
            wr_word = {lat_ip_ff, lat_port_ff, lat_exp_ff};
         end
         WSEL_APPEND: begin
            wr_addr = IDX_W'(count_ff);
            wr_word = {lat_ip_ff, lat_port_ff, lat_exp_ff};
         end
         WSEL_MOVE: begin
            wr_addr = idx_ff;
            wr_word = rd_word;
         end
         default: begin
            wr_addr = idx_ff;
            wr_word = {lat_ip_ff, lat_port_ff, lat_exp_ff};
         end
      endcase
   end

   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.idx_last   = ((CNT1_W'(idx_ff) + CNT1_W'(1)) == CNT1_W'(count_ff));
      sts.full       = (count_ff == CNT_W'(TABLE_ENTRIES));
      sts.hit        = (rd_ip == lat_ip_ff) && (rd_port == lat_port_ff);
      sts.expired    = (rd_exp <= EXP_W'(now_ff));
      sts.slot_free  = slot_free;
   end

   always_comb begin
      def_span_in = def_span_ff;
      max_span_in = max_span_ff;
      if (csr_valid) begin
         unique case (lte_csr_type'(csr_index))
            CSR_DEFAULT_SPAN: def_span_in = csr_data[DEFSPAN_W-1:0];
            CSR_MAX_SPAN:     max_span_in = csr_data[MAXSPAN_W-1:0];
         endcase
      end
   end

   always_comb begin
      now_in = now_ff;
      if (cmd.now_inc && (now_ff != '1)) begin
         now_in = now_ff + IP_W'(1);
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_span_ff  <= DEF_SPAN_RST;
         max_span_ff  <= MAX_SPAN_RST;
         now_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         def_span_ff  <= def_span_in;
         max_span_ff  <= max_span_in;
         now_ff       <= now_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         lat_ip_ff   <= req_addr_ip;
         lat_port_ff <= req_addr_port;
         lat_exp_ff  <= new_exp;
      end
      if (cmd.set_status) begin
         pend_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_count_ff <= COUNT_W'(count_ff);
         unique case (cmd.rld)
            RLD_PEND: begin
               rsp_status_ff <= pend_ff;
               rsp_ip_ff     <= '0;
               rsp_port_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
            RLD_ENTRY: begin
               rsp_status_ff <= ST_LISTED;
               rsp_ip_ff     <= rd_ip;
               rsp_port_ff   <= rd_port;
               rsp_last_ff   <= sts.idx_last;
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_ip    = rsp_ip_ff;
   assign rsp_entry_port  = rsp_port_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("Live count exceeds the table size.");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.wsel == WSEL_APPEND)) |-> !sts.full)
      else $error("Append issued on a full table.");

   a_remove_live: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> !sts.count_zero)
      else $error("Entry removed from an empty table.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("Result register overwritten before it was taken.");

   a_tick_saturates: assert property (@(posedge clock) disable iff (reset)
      (cmd.now_inc && (now_ff == '1)) |=> (now_ff == '1))
      else $error("Seconds counter wrapped.");
`endif

endmodule

`default_nettype wire
